FILE: hdl/lobm_pkg.sv
// Shared types and result codes for the limit order book matcher.
// No dependencies; every other file in hdl/ imports this package.
package lobm_pkg;

  typedef logic [1:0] kind_t;

  localparam kind_t KIND_TRADE   = 2'd0;
  localparam kind_t KIND_RESTED  = 2'd1;
  localparam kind_t KIND_FILLED  = 2'd2;
  localparam kind_t KIND_DROPPED = 2'd3;

  // Best crossing candidate carried down the cell chain.
  typedef struct packed {
    logic        found;
    logic [31:0] price;
    logic [31:0] rem;
    logic [31:0] ident;
    logic [31:0] age;
  } cand_t;

  // Contents written into a free cell when a remainder rests.
  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] rem;
    logic [31:0] ident;
    logic [31:0] stamp;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_SCAN,
    ST_FIN
  } lobm_state_t;

endpackage

FILE: hdl/lobm_cell.sv
// One book entry plus one stage of the priority scan chain.
// Depends on lobm_pkg for the candidate and entry types.
module lobm_cell #(
  parameter int IDX_W    = 5,
  parameter int CELL_IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 order_side,
  input  logic [31:0]          order_limit,
  input  logic [31:0]          arrival_cnt,
  input  logic                 tok_in,
  input  lobm_pkg::cand_t      cand_in,
  input  logic [IDX_W-1:0]     cand_idx_in,
  input  logic                 free_found_in,
  input  logic [IDX_W-1:0]     free_idx_in,
  output logic                 tok_out,
  output lobm_pkg::cand_t      cand_out,
  output logic [IDX_W-1:0]     cand_idx_out,
  output logic                 free_found_out,
  output logic [IDX_W-1:0]     free_idx_out,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  lobm_pkg::entry_t     wr_data,
  input  logic                 upd_en,
  input  logic [IDX_W-1:0]     upd_idx,
  input  logic [31:0]          upd_rem
);
  import lobm_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_IDX);

  logic        valid_r;
  entry_t      ent_r;
  logic        tok_r;
  cand_t       cand_r;
  logic [IDX_W-1:0] cand_idx_r;
  logic        free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  logic        crosses;
  logic        better;
  logic [31:0] my_age;

  always_comb begin
    my_age  = arrival_cnt - ent_r.stamp;
    crosses = valid_r && (ent_r.side != order_side) &&
              (order_side ? (ent_r.price >= order_limit) : (ent_r.price <= order_limit));
    if (!cand_in.found) begin
      better = 1'b1;
    end else if (ent_r.price == cand_in.price) begin
      better = my_age > cand_in.age;
    end else begin
      better = order_side ? (ent_r.price > cand_in.price) : (ent_r.price < cand_in.price);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= 1'b0;
    end else begin
      tok_r <= tok_in;
      if (wr_en && wr_idx == MY_IDX) begin
        valid_r <= 1'b1;
      end else if (upd_en && upd_idx == MY_IDX && upd_rem == 32'd0) begin
        valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && wr_idx == MY_IDX) begin
      ent_r <= wr_data;
    end else if (upd_en && upd_idx == MY_IDX) begin
      ent_r.rem <= upd_rem;
    end
    if (crosses && better) begin
      cand_r     <= '{found: 1'b1, price: ent_r.price, rem: ent_r.rem,
                      ident: ent_r.ident, age: my_age};
      cand_idx_r <= MY_IDX;
    end else begin
      cand_r     <= cand_in;
      cand_idx_r <= cand_idx_in;
    end
    if (!free_found_in && !valid_r) begin
      free_found_r <= 1'b1;
      free_idx_r   <= MY_IDX;
    end else begin
      free_found_r <= free_found_in;
      free_idx_r   <= free_idx_in;
    end
  end

  assign tok_out        = tok_r;
  assign cand_out       = cand_r;
  assign cand_idx_out   = cand_idx_r;
  assign free_found_out = free_found_r;
  assign free_idx_out   = free_idx_r;

endmodule

FILE: hdl/limit_order_book_matcher_core.sv
// Top level of the price/time priority limit order matcher.
// Depends on lobm_pkg and lobm_cell.
//
//   channel  | handshake            | word
//   ---------+----------------------+------------------------------------------
//   order in | start, busy          | in_order_side/price/qty/id
//   result   | out_valid (strobe)   | out_result_kind ... out_last_result
//
// Every search for the best crossing entry sends a token down the chain of
// BOOK_DEPTH cells, one cell per cycle. The final result is the last scan's word,
// or, after a fill that completes the order, a word from the FIN state.
// An order with zero quantity is answered the cycle after it is taken.
// Reset empties the book and clears the arrival counter.
// Results appear for one cycle each; the receiver cannot hold them off.
module limit_order_book_matcher_core #(
  parameter int BOOK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_order_side,
  input  logic [31:0] in_order_price,
  input  logic [31:0] in_order_qty,
  input  logic [31:0] in_order_id,
  output logic        out_valid,
  output logic [1:0]  out_result_kind,
  output logic        out_aggressor_side,
  output logic [31:0] out_maker_id,
  output logic [31:0] out_trade_price,
  output logic [31:0] out_trade_qty,
  output logic        out_last_result
);
  import lobm_pkg::*;

  localparam int IDX_W = $clog2(BOOK_DEPTH);

  lobm_state_t state_r, state_nxt;
  logic        side_r;
  logic [31:0] price_r, qty_r, qty_nxt, id_r, cnt_r, cnt_nxt;
  logic        side_nxt;
  logic [31:0] price_nxt, id_nxt;

  logic        ov_r, ov_nxt;
  kind_t       okind_r, okind_nxt;
  logic [31:0] omaker_r, omaker_nxt, oprice_r, oprice_nxt, oqty_r, oqty_nxt;
  logic        olast_r, olast_nxt;

  logic                 tok        [BOOK_DEPTH+1];
  cand_t                cand       [BOOK_DEPTH+1];
  logic [IDX_W-1:0]     cand_idx   [BOOK_DEPTH+1];
  logic                 free_found [BOOK_DEPTH+1];
  logic [IDX_W-1:0]     free_idx   [BOOK_DEPTH+1];
  logic [BOOK_DEPTH-1:0] tok_v;

  logic             wr_en, upd_en;
  entry_t           wr_data;
  logic [31:0]      upd_rem, fill;
  cand_t            best;

  assign tok[0]        = (state_r == ST_LAUNCH);
  assign cand[0]       = '0;
  assign cand_idx[0]   = '0;
  assign free_found[0] = 1'b0;
  assign free_idx[0]   = '0;
  assign best          = cand[BOOK_DEPTH];

  for (genvar g = 0; g < BOOK_DEPTH; g++) begin : g_cell
    lobm_cell #(.IDX_W(IDX_W), .CELL_IDX(g)) u_cell (
      .clk           (clk),
      .rst_n         (rst_n),
      .order_side    (side_r),
      .order_limit   (price_r),
      .arrival_cnt   (cnt_r),
      .tok_in        (tok[g]),
      .cand_in       (cand[g]),
      .cand_idx_in   (cand_idx[g]),
      .free_found_in (free_found[g]),
      .free_idx_in   (free_idx[g]),
      .tok_out       (tok[g+1]),
      .cand_out      (cand[g+1]),
      .cand_idx_out  (cand_idx[g+1]),
      .free_found_out(free_found[g+1]),
      .free_idx_out  (free_idx[g+1]),
      .wr_en         (wr_en),
      .wr_idx        (free_idx[BOOK_DEPTH]),
      .wr_data       (wr_data),
      .upd_en        (upd_en),
      .upd_idx       (cand_idx[BOOK_DEPTH]),
      .upd_rem       (upd_rem)
    );
    assign tok_v[g] = tok[g+1];
  end

  assign fill    = (qty_r < best.rem) ? qty_r : best.rem;
  assign upd_rem = best.rem - fill;
  assign wr_data = '{side: side_r, price: price_r, rem: qty_r, ident: id_r, stamp: cnt_r};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && in_order_qty != 32'd0) begin
          state_nxt = ST_LAUNCH;
        end
      end
      ST_LAUNCH: state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (tok[BOOK_DEPTH]) begin
          if (!best.found) begin
            state_nxt = ST_IDLE;
          end else if (qty_r == fill) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_LAUNCH;
          end
        end
      end
      ST_FIN:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and result word.
  always_comb begin
    side_nxt   = side_r;
    price_nxt  = price_r;
    qty_nxt    = qty_r;
    id_nxt     = id_r;
    cnt_nxt    = cnt_r;
    ov_nxt     = 1'b0;
    okind_nxt  = KIND_FILLED;
    omaker_nxt = 32'd0;
    oprice_nxt = price_r;
    oqty_nxt   = 32'd0;
    olast_nxt  = 1'b0;
    wr_en      = 1'b0;
    upd_en     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          side_nxt  = in_order_side;
          price_nxt = in_order_price;
          qty_nxt   = in_order_qty;
          id_nxt    = in_order_id;
          if (in_order_qty == 32'd0) begin
            ov_nxt     = 1'b1;
            okind_nxt  = KIND_FILLED;
            oprice_nxt = in_order_price;
            olast_nxt  = 1'b1;
            cnt_nxt    = cnt_r + 32'd1;
          end
        end
      end
      ST_SCAN: begin
        if (tok[BOOK_DEPTH]) begin
          ov_nxt = 1'b1;
          if (best.found) begin
            upd_en     = 1'b1;
            okind_nxt  = KIND_TRADE;
            omaker_nxt = best.ident;
            oprice_nxt = best.price;
            oqty_nxt   = fill;
            qty_nxt    = qty_r - fill;
          end else begin
            olast_nxt = 1'b1;
            oqty_nxt  = qty_r;
            cnt_nxt   = cnt_r + 32'd1;
            if (free_found[BOOK_DEPTH]) begin
              wr_en     = 1'b1;
              okind_nxt = KIND_RESTED;
            end else begin
              okind_nxt = KIND_DROPPED;
            end
          end
        end
      end
      ST_FIN: begin
        ov_nxt    = 1'b1;
        okind_nxt = KIND_FILLED;
        olast_nxt = 1'b1;
        cnt_nxt   = cnt_r + 32'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= 32'd0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    side_r   <= side_nxt;
    price_r  <= price_nxt;
    qty_r    <= qty_nxt;
    id_r     <= id_nxt;
    okind_r  <= okind_nxt;
    omaker_r <= omaker_nxt;
    oprice_r <= oprice_nxt;
    oqty_r   <= oqty_nxt;
    olast_r  <= olast_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = ov_r;
  assign out_result_kind    = okind_r;
  assign out_aggressor_side = side_r;
  assign out_maker_id       = omaker_r;
  assign out_trade_price    = oprice_r;
  assign out_trade_qty      = oqty_r;
  assign out_last_result    = olast_r;

  // Only one scan token may travel the chain at a time.
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n) $onehot0(tok_v))
    else $error("more than one scan token in the cell chain");

  // A trade always moves a nonzero quantity.
  a_trade_qty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_TRADE) |-> (out_trade_qty != 32'd0))
    else $error("trade with zero quantity");

  // The final word of an order coincides with the block going idle.
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_result) |-> !busy)
    else $error("final result while still busy");

endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for limit_order_book_matcher_core.
// Holds a price/time priority book predictor inside a small scoreboard class.
// Depends on lobm_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import lobm_pkg::*;

  localparam int DEPTH = 32;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    kind_t       kind;
    logic        side;
    logic [31:0] maker;
    logic [31:0] price;
    logic [31:0] qty;
    logic        last;
  } fill_word_t;

  class book_scoreboard;
    bit          live[DEPTH];
    bit          rside[DEPTH];
    logic [31:0] rprice[DEPTH];
    logic [31:0] rqty[DEPTH];
    logic [31:0] rid[DEPTH];
    logic [31:0] rstamp[DEPTH];
    logic [31:0] arrivals;
    fill_word_t  pending[$];
    int          mismatches;

    function new();
      for (int i = 0; i < DEPTH; i++) live[i] = 0;
      arrivals = 0;
      mismatches = 0;
    endfunction

    function void enqueue(fill_word_t w);
      pending.insert(pending.size(), w);
    endfunction

    function int best_match(bit side, logic [31:0] limit);
      int best;
      bit better;
      best = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (!live[i] || rside[i] == side) continue;
        if (side == 0 ? rprice[i] > limit : rprice[i] < limit) continue;
        if (best < 0) begin
          best = i;
          continue;
        end
        if (rprice[i] == rprice[best])
          better = (arrivals - rstamp[i]) > (arrivals - rstamp[best]);
        else if (side == 0)
          better = rprice[i] < rprice[best];
        else
          better = rprice[i] > rprice[best];
        if (better) best = i;
      end
      return best;
    endfunction

    function void note_order(bit side, logic [31:0] price, logic [31:0] qty,
                             logic [31:0] id);
      int b;
      int slot;
      logic [31:0] fill;
      fill_word_t w;
      slot = -1;
      while (qty != 0) begin
        b = best_match(side, price);
        if (b < 0) break;
        fill = qty < rqty[b] ? qty : rqty[b];
        w = '{KIND_TRADE, side, rid[b], rprice[b], fill, 1'b0};
        enqueue(w);
        qty -= fill;
        rqty[b] -= fill;
        if (rqty[b] == 0) live[b] = 0;
      end
      if (qty == 0) begin
        w = '{KIND_FILLED, side, 32'd0, price, 32'd0, 1'b1};
      end else begin
        for (int i = 0; i < DEPTH; i++)
          if (!live[i] && slot < 0) slot = i;
        if (slot < 0) begin
          w = '{KIND_DROPPED, side, 32'd0, price, qty, 1'b1};
        end else begin
          live[slot] = 1;
          rside[slot] = side;
          rprice[slot] = price;
          rqty[slot] = qty;
          rid[slot] = id;
          rstamp[slot] = arrivals;
          w = '{KIND_RESTED, side, 32'd0, price, qty, 1'b1};
        end
      end
      enqueue(w);
      arrivals++;
    endfunction

    function void check_result(fill_word_t got);
      fill_word_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word kind=%0d", got.kind);
        return;
      end
      exp = pending.pop_front();
      if (got !== exp) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: exp k=%0d s=%0d m=%0h p=%0h q=%0h l=%0d,",
                    " got k=%0d s=%0d m=%0h p=%0h q=%0h l=%0d"},
                   exp.kind, exp.side, exp.maker, exp.price, exp.qty, exp.last,
                   got.kind, got.side, got.maker, got.price, got.qty, got.last);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic        in_order_side = 0;
  logic [31:0] in_order_price = 0;
  logic [31:0] in_order_qty = 0;
  logic [31:0] in_order_id = 0;
  logic        out_valid;
  logic [1:0]  out_result_kind;
  logic        out_aggressor_side;
  logic [31:0] out_maker_id;
  logic [31:0] out_trade_price;
  logic [31:0] out_trade_qty;
  logic        out_last_result;

  book_scoreboard book = new();
  int idle_cycles = 0;
  bit steady = 0;

  always #1 clk = ~clk;

  limit_order_book_matcher_core #(.BOOK_DEPTH(DEPTH)) dut (.*);

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        book.check_result('{out_result_kind, out_aggressor_side, out_maker_id,
                            out_trade_price, out_trade_qty, out_last_result});
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Holds the word until it is taken; the next word follows on the same edge.
  task automatic send_order(bit side, logic [31:0] price, logic [31:0] qty,
                            logic [31:0] id);
    while (!steady && $urandom_range(99) < 7) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_order_side <= side;
    in_order_price <= price;
    in_order_qty <= qty;
    in_order_id <= id;
    @(posedge clk);
    while (busy) @(posedge clk);
    book.note_order(side, price, qty, id);
  endtask

  task automatic random_order(int n);
    logic [31:0] p;
    logic [31:0] q;
    for (int k = 0; k < n; k++) begin
      // Most prices cluster near 1000 so orders cross; a few are wild.
      if ($urandom_range(9) == 0) p = $urandom();
      else p = 1000 + $urandom_range(12);
      case ($urandom_range(9))
        0: q = 0;
        1: q = $urandom();
        2: q = 32'hFFFF_FFFF - $urandom_range(3);
        default: q = 1 + $urandom_range(40);
      endcase
      send_order(1'($urandom_range(1)), p, q, $urandom());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // Directed: zero quantity, extremes, price ties by age, full book, sweep.
    send_order(0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    send_order(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_order(0, 32'hFFFF_FFFF, 32'd5, 32'd1);
    send_order(0, 32'd0, 32'd1, 32'd0);
    send_order(1, 32'd0, 32'd1, 32'd2);
    send_order(1, 32'd100, 32'd3, 32'd123);
    send_order(1, 32'd100, 32'd3, 32'd456);
    send_order(1, 32'd99, 32'd2, 32'd7);
    send_order(0, 32'd100, 32'd6, 32'd8);
    for (int i = 0; i < 34; i++) send_order(i[0], 32'd500 + i[0], 32'd2, i);
    send_order(0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hAAAA_5555);
    send_order(1, 32'd0, 32'hFFFF_FFFF, 32'h5555_AAAA);
    random_order(100);
    steady = 1;
    random_order(60);
    steady = 0;
    random_order(75);
    start <= 0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end
endmodule

FILE: files.f
hdl/lobm_pkg.sv
hdl/lobm_cell.sv
hdl/limit_order_book_matcher_core.sv
tb/sv/tb.sv
